// ----- rtl/bcp_pkg.sv -----
// bcp_pkg: constants, phase codes and the letter lookup for the bracketed command parser
// no dependencies

package bcp_pkg;

    localparam int MAX_DIGITS_DEF = 9;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 5;
    localparam int VALUE_W  = 30;
    localparam int COUNT_W  = 5;
    localparam int PHASE_W  = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [7:0] STEER_RESET = 8'd2;

    // frame phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LETTER = 2'd2;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LP      = 5'd0;
    localparam logic [ACTION_W-1:0] ACT_LD      = 5'd1;
    localparam logic [ACTION_W-1:0] ACT_LI      = 5'd2;
    localparam logic [ACTION_W-1:0] ACT_UP      = 5'd3;
    localparam logic [ACTION_W-1:0] ACT_UI      = 5'd4;
    localparam logic [ACTION_W-1:0] ACT_UD      = 5'd5;
    localparam logic [ACTION_W-1:0] ACT_RUN_R   = 5'd6;
    localparam logic [ACTION_W-1:0] ACT_STOP_R  = 5'd7;
    localparam logic [ACTION_W-1:0] ACT_RUN_O   = 5'd8;
    localparam logic [ACTION_W-1:0] ACT_STOP_O  = 5'd9;
    localparam logic [ACTION_W-1:0] ACT_STEER0  = 5'd10;
    localparam logic [ACTION_W-1:0] ACT_STEER1  = 5'd11;
    localparam logic [ACTION_W-1:0] ACT_UC      = 5'd12;
    localparam logic [ACTION_W-1:0] ACT_STEER_V = 5'd13;
    localparam logic [ACTION_W-1:0] ACT_UX      = 5'd14;
    localparam logic [ACTION_W-1:0] ACT_UY      = 5'd15;
    localparam logic [ACTION_W-1:0] ACT_UB      = 5'd16;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 5'd17;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic [ACTION_W-1:0] letter_code(input logic [7:0] b);
        logic [ACTION_W-1:0] c;
        case (b)
            8'h70:   c = ACT_LP;      // p
            8'h64:   c = ACT_LD;      // d
            8'h69:   c = ACT_LI;      // i
            8'h50:   c = ACT_UP;      // P
            8'h49:   c = ACT_UI;      // I
            8'h44:   c = ACT_UD;      // D
            8'h52:   c = ACT_RUN_R;   // R
            8'h72:   c = ACT_STOP_R;  // r
            8'h4f:   c = ACT_RUN_O;   // O
            8'h6f:   c = ACT_STOP_O;  // o
            8'h4a:   c = ACT_STEER0;  // J
            8'h6a:   c = ACT_STEER1;  // j
            8'h43:   c = ACT_UC;      // C
            8'h63:   c = ACT_STEER_V; // c
            8'h58:   c = ACT_UX;      // X
            8'h59:   c = ACT_UY;      // Y
            8'h42:   c = ACT_UB;      // B
            default: c = ACT_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/bracketed_command_parser.sv -----
// bracketed_command_parser: frame parser for '(' letter digits ')' byte streams
// depends on bcp_pkg

// usage
//   input channel: i_valid / o_stall with one received byte per item on i_rx_byte
//   output channel: o_valid / i_stall; one item per closing ')' that follows a letter,
//   carrying o_action, o_value, o_digit_overflow, o_run_direction, o_steer_direction
//   an item is taken at a clock edge where valid is high and stall is low
// timing
//   one byte per cycle while o_stall is low; the per-byte work is one compare and a
//   multiply-by-ten add between the input register and the frame/result registers
//   each byte is held in the input register, and a result is written to the result
//   register when its ')' byte leaves the input register, then shows on the output
// stall behavior
//   the result register holds while i_stall is high; bytes that give no result
//   keep flowing through the parser, only a ')' that closes a frame waits
//   for the result register, and then o_stall is raised
// reset
//   synchronous active-low i_rst_n empties both registers, returns the parser
//   to idle, clears the run flag and sets the steer byte to 2
module bracketed_command_parser #(
    parameter int MAX_DIGITS = bcp_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bcp_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bcp_pkg::ACTION_W-1:0]  o_action,
    output logic [bcp_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_digit_overflow,
    output logic                          o_run_direction,
    output logic [7:0]                    o_steer_direction
);

    // input register
    logic                        r_in_valid;
    logic [bcp_pkg::BYTE_W-1:0]  r_in_byte;

    // frame state
    logic [bcp_pkg::PHASE_W-1:0] r_phase,  n_phase;
    logic [7:0]                  r_letter, n_letter;
    logic [bcp_pkg::VALUE_W-1:0] r_acc,    n_acc;
    logic [bcp_pkg::COUNT_W-1:0] r_count,  n_count;
    logic                        r_ovf,    n_ovf;
    logic                        r_run,    n_run;
    logic [7:0]                  r_steer,  n_steer;

    // result register
    logic                         r_out_valid;
    logic [bcp_pkg::ACTION_W-1:0] r_action;
    logic [bcp_pkg::VALUE_W-1:0]  r_value;
    logic                         r_out_ovf;
    logic                         r_out_run;
    logic [7:0]                   r_out_steer;

    logic                         out_free;
    logic                         is_emit;
    logic                         proc;
    logic [bcp_pkg::VALUE_W+3:0]  acc_next;
    logic [bcp_pkg::ACTION_W-1:0] code;

    // a closing byte in letter phase produces a result
    assign is_emit  = (r_in_byte == bcp_pkg::CH_CLOSE) && (r_phase == bcp_pkg::PH_LETTER);
    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && (!is_emit || out_free);
    assign o_stall  = r_in_valid && !proc;

    // acc*10 + digit as shifts and adds
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {26'd0, (r_in_byte - bcp_pkg::CH_ZERO)};
    assign code = bcp_pkg::letter_code(r_letter);

    always_comb begin
        n_phase  = r_phase;
        n_letter = r_letter;
        n_acc    = r_acc;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_run    = r_run;
        n_steer  = r_steer;
        if (r_in_byte == bcp_pkg::CH_OPEN) begin
            // open bracket restarts the frame from any phase
            n_phase  = bcp_pkg::PH_OPEN;
            n_letter = 8'd0;
            n_acc    = '0;
            n_count  = '0;
            n_ovf    = 1'b0;
        end else if (r_phase == bcp_pkg::PH_OPEN && bcp_pkg::is_letter(r_in_byte)) begin
            n_letter = r_in_byte;
            n_phase  = bcp_pkg::PH_LETTER;
        end else if (r_phase == bcp_pkg::PH_LETTER && bcp_pkg::is_digit(r_in_byte)) begin
            if (r_count < bcp_pkg::COUNT_W'(MAX_DIGITS)) begin
                if (acc_next > {4'd0, bcp_pkg::VALUE_MAX}) begin
                    n_acc = bcp_pkg::VALUE_MAX;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = acc_next[bcp_pkg::VALUE_W-1:0];
                end
                n_count = r_count + bcp_pkg::COUNT_W'(1);
            end else begin
                // digits past the limit are dropped
                n_ovf = 1'b1;
            end
        end else if (r_in_byte == bcp_pkg::CH_CLOSE) begin
            if (r_phase == bcp_pkg::PH_LETTER) begin
                case (code)
                    bcp_pkg::ACT_RUN_R, bcp_pkg::ACT_RUN_O:   n_run = 1'b1;
                    bcp_pkg::ACT_STOP_R, bcp_pkg::ACT_STOP_O: n_run = 1'b0;
                    bcp_pkg::ACT_STEER0:  n_steer = 8'd0;
                    bcp_pkg::ACT_STEER1:  n_steer = 8'd1;
                    bcp_pkg::ACT_STEER_V: n_steer = 8'd0 - r_acc[7:0];
                    default: ;
                endcase
            end
            // close without a letter just drops the frame
            n_phase  = bcp_pkg::PH_IDLE;
            n_letter = 8'd0;
            n_acc    = '0;
            n_count  = '0;
            n_ovf    = 1'b0;
        end
    end

    // input register: refill whenever it empties or moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bcp_pkg::PH_IDLE;
            r_letter <= 8'd0;
            r_acc    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_run    <= 1'b0;
            r_steer  <= bcp_pkg::STEER_RESET;
        end else if (proc) begin
            r_phase  <= n_phase;
            r_letter <= n_letter;
            r_acc    <= n_acc;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_run    <= n_run;
            r_steer  <= n_steer;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && is_emit;
        end
        if (proc && is_emit) begin
            r_action    <= code;
            r_value     <= r_acc;
            r_out_ovf   <= r_ovf;
            r_out_run   <= n_run;
            r_out_steer <= n_steer;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_action          = r_action;
    assign o_value           = r_value;
    assign o_digit_overflow  = r_out_ovf;
    assign o_run_direction   = r_out_run;
    assign o_steer_direction = r_out_steer;

endmodule
